>>> hdl/double_ended_queue_unit_macros.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define DEQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");
// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/deq_pkg.sv
// Shared types and defaults for the double-ended queue unit.
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 8;

   // command codes on req_cmd
   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   // status codes on rsp_status
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // per-cycle operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD       = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_CLEAR      = 3'd5
   } cell_op_type;

endpackage

`default_nettype wire

>>> hdl/deq_cell.sv
// One cell of the deque chain: front-ordered and back-ordered copies plus occupancy.
`default_nettype none

module deq_cell #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire deq_pkg::cell_op_type  op,
   input  wire logic [DATA_WIDTH-1:0] push_value,
   input  wire logic [DATA_WIDTH-1:0] left_a,
   input  wire logic [DATA_WIDTH-1:0] left_b,
   input  wire logic                  left_occ,
   input  wire logic [DATA_WIDTH-1:0] right_a,
   input  wire logic [DATA_WIDTH-1:0] right_b,
   input  wire logic                  right_occ,
   output logic      [DATA_WIDTH-1:0] a_ff,
   output logic      [DATA_WIDTH-1:0] b_ff,
   output logic                       occ_ff
);

   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] a_in;
   logic [DATA_WIDTH-1:0] b_in;
   logic                  occ_in;
   logic                  tail;

   // chain a holds the queue front first, chain b holds it back first;
   // tail marks the first free cell, where an end write lands
   always_comb begin
      tail   = !occ_ff && left_occ;
      a_in   = a_ff;
      b_in   = b_ff;
      occ_in = occ_ff;
      case (op)
         OP_PUSH_BACK: begin
            if (tail) a_in = push_value;
            b_in   = left_b;
            occ_in = left_occ;
         end
         OP_PUSH_FRONT: begin
            a_in   = left_a;
            if (tail) b_in = push_value;
            occ_in = left_occ;
         end
         OP_POP_FRONT: begin
            a_in   = right_a;
            occ_in = right_occ;
         end
         OP_POP_BACK: begin
            b_in   = right_b;
            occ_in = right_occ;
         end
         OP_CLEAR: begin
            occ_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // occupancy is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // element data, no reset
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

`default_nettype wire

>>> hdl/double_ended_queue_unit.sv
// Bounded double-ended queue built as a chain of shifting cells.
// The result of a command is registered and is valid in the cycle after its request beat.
// Throughput: one command per cycle while rsp_ready stays high; every cell
// shifts or writes together with the command it serves, so the chain sets no limit of its own.
// A new request is taken only when no result is pending or the pending result leaves in that cycle.
// Reset (synchronous): empties the queue, clears count, status and rsp_valid.
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [DATA_WIDTH-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [DATA_WIDTH-1:0] rsp_front_value,
   output logic                       rsp_front_valid,
   output logic      [DATA_WIDTH-1:0] rsp_back_value,
   output logic                       rsp_back_valid,
   output logic      [CNT_W-1:0]      rsp_count,
   output logic                       rsp_is_empty,
   output logic      [1:0]            rsp_status
);

   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] a_q [DEPTH];
   logic [DATA_WIDTH-1:0] b_q [DEPTH];
   logic [DEPTH-1:0]      occ_q;

   cell_op_type           op;
   status_type            status_ff, status_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  full;
   logic                  empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = occ_q[DEPTH-1];
   assign empty     = !occ_q[0];

   // command decode: dropped commands leave the chain alone
   always_comb begin
      op        = OP_HOLD;
      status_in = status_ff;
      count_in  = count_ff;
      if (accept) begin
         status_in = STAT_OK;
         unique case (req_cmd)
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  op       = OP_PUSH_BACK;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  op       = OP_PUSH_FRONT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  op       = OP_POP_FRONT;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  op       = OP_POP_BACK;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_CLEAR: begin
               op       = OP_CLEAR;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result beat handshake
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= STAT_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   // cell chain; the left end feeds the pushed value, the right end feeds nothing
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] la, lb, ra, rb;
      logic                  lo, ro;

      if (i == 0) begin : g_left_end
         assign la = req_value;
         assign lb = req_value;
         assign lo = 1'b1;
      end else begin : g_left_link
         assign la = a_q[i-1];
         assign lb = b_q[i-1];
         assign lo = occ_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_right_end
         assign ra = a_q[i];
         assign rb = b_q[i];
         assign ro = 1'b0;
      end else begin : g_right_link
         assign ra = a_q[i+1];
         assign rb = b_q[i+1];
         assign ro = occ_q[i+1];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .push_value (req_value),
         .left_a     (la),
         .left_b     (lb),
         .left_occ   (lo),
         .right_a    (ra),
         .right_b    (rb),
         .right_occ  (ro),
         .a_ff       (a_q[i]),
         .b_ff       (b_q[i]),
         .occ_ff     (occ_q[i])
      );
   end

   // result fields come straight from the head cells and counters
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = occ_q[0] ? a_q[0] : '0;
   assign rsp_front_valid = occ_q[0];
   assign rsp_back_value  = occ_q[0] ? b_q[0] : '0;
   assign rsp_back_valid  = occ_q[0];
   assign rsp_count       = count_ff;
   assign rsp_is_empty    = !occ_q[0];
   assign rsp_status      = status_ff;

   // counter and occupancy chain must agree at both ends
   `DEQ_ASSERT_IMPL(a_empty_match, clock, reset, 1'b1, (count_ff == '0) == !occ_q[0])
   `DEQ_ASSERT_IMPL(a_full_match, clock, reset, 1'b1, (count_ff == CNT_W'(DEPTH)) == occ_q[DEPTH-1])
   // with one element, both copies hold the same value
   `DEQ_ASSERT_IMPL(a_single_same, clock, reset, count_ff == CNT_W'(1), a_q[0] == b_q[0])
   // a taken push on a non-full queue grows the count by one
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset, accept && !full && (req_cmd == CMD_PUSH_BACK || req_cmd == CMD_PUSH_FRONT), count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire

>>> sim/double_ended_queue_unit_test.sv
// Self-checking testbench for the double-ended queue unit: directed, random and stall tests.
`timescale 1ns / 1ps

module double_ended_queue_unit_test;
   import deq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES = 250;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_BEATS = 950;

   // command codes the block treats as no-ops
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // receiver stall modes
   localparam int READY_ALWAYS  = 0;
   localparam int READY_RANDOM  = 1;
   localparam int READY_PATTERN = 2;

   // one result beat as the block should report it
   typedef struct {
      logic [DATA_WIDTH-1:0] front_value;
      logic                  front_valid;
      logic [DATA_WIDTH-1:0] back_value;
      logic                  back_valid;
      logic [CNT_W-1:0]      count;
      logic                  is_empty;
      status_type            status;
   } deque_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_cmd = '0;
   logic [DATA_WIDTH-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_front_value;
   logic                  rsp_front_valid;
   logic [DATA_WIDTH-1:0] rsp_back_value;
   logic                  rsp_back_valid;
   logic [CNT_W-1:0]      rsp_count;
   logic                  rsp_is_empty;
   logic [1:0]            rsp_status;

   // predicted deque contents
   logic [DATA_WIDTH-1:0] model_slots [DEPTH];
   int                    model_head = 0;
   int                    model_held = 0;
   deque_view_type        expected_views [$];

   int error_count = 0;
   int stall_cycles = 0;

   // sender and receiver pacing
   int   burst_left = 0;
   bit   steady_sender = 1'b0;
   bit   rsp_steady = 1'b0;
   bit   hold_request = 1'b0;
   int   hold_left = 0;
   int   ready_mode = READY_ALWAYS;
   int   mode_left = 0;
   logic [7:0] pattern_bits = 8'hFF;
   logic [2:0] pattern_pos = '0;

   double_ended_queue_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_front_valid (rsp_front_valid),
      .rsp_back_value  (rsp_back_value),
      .rsp_back_valid  (rsp_back_valid),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   always #HALF_PERIOD clock = ~clock;

   // apply one command to the predicted deque and queue the view it leaves
   task automatic model_deque_command(input logic [2:0] code,
                                      input logic [DATA_WIDTH-1:0] value);
      deque_view_type view;
      view.status = STAT_OK;
      case (code)
         CMD_PUSH_BACK: begin
            if (model_held >= DEPTH) view.status = STAT_FULL;
            else begin
               model_slots[(model_head + model_held) % DEPTH] = value;
               model_held++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (model_held >= DEPTH) view.status = STAT_FULL;
            else begin
               model_head = (model_head + DEPTH - 1) % DEPTH;
               model_slots[model_head] = value;
               model_held++;
            end
         end
         CMD_POP_FRONT: begin
            if (model_held == 0) view.status = STAT_EMPTY;
            else begin
               model_head = (model_head + 1) % DEPTH;
               model_held--;
            end
         end
         CMD_POP_BACK: begin
            if (model_held == 0) view.status = STAT_EMPTY;
            else model_held--;
         end
         CMD_CLEAR: begin
            model_head = 0;
            model_held = 0;
         end
         default: ;
      endcase
      // empty deque reports zero values with both valid flags low
      if (model_held == 0) begin
         view.front_value = '0;
         view.back_value  = '0;
      end else begin
         view.front_value = model_slots[model_head];
         view.back_value  = model_slots[(model_head + model_held - 1) % DEPTH];
      end
      view.front_valid = (model_held != 0);
      view.back_valid  = (model_held != 0);
      view.count       = CNT_W'(model_held);
      view.is_empty    = (model_held == 0);
      expected_views.push_back(view);
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // predict on each command beat, compare each result beat
   always @(posedge clock) begin : monitor
      deque_view_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (req_valid && req_ready) model_deque_command(req_cmd, req_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing expected, expected none, actual count %0d",
                        $time, rsp_count);
            end else begin
               want = expected_views.pop_front();
               check_field("front_value", want.front_value, rsp_front_value);
               check_field("front_valid", 8'(want.front_valid), 8'(rsp_front_valid));
               check_field("back_value", want.back_value, rsp_back_value);
               check_field("back_valid", 8'(want.back_valid), 8'(rsp_back_valid));
               check_field("count", 8'(want.count), 8'(rsp_count));
               check_field("is_empty", 8'(want.is_empty), 8'(rsp_is_empty));
               check_field("status", 8'(want.status), 8'(rsp_status));
            end
         end
      end
   end

   // receiver: long hold-off on request, else mixed stall modes
   always @(negedge clock) begin : receiver
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            ready_mode   = $urandom_range(READY_PATTERN, READY_ALWAYS);
            mode_left    = $urandom_range(60, 10);
            pattern_bits = $urandom_range(255, 1);
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= ($urandom_range(99, 0) < 65);
            default: begin
               rsp_ready <= pattern_bits[pattern_pos];
               pattern_pos++;
            end
         endcase
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // offer one command beat and wait until it is taken
   task automatic send_command(input logic [2:0] code, input logic [DATA_WIDTH-1:0] value);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         gap = $urandom_range(8, 1);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(24, 1);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd   <= code;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DATA_WIDTH-1:0] random_value();
      return DATA_WIDTH'($urandom_range(255, 0));
   endfunction

   // empty pops, value extremes, fill to capacity, full pushes, spare codes, clear
   task automatic test_directed_cases();
      send_command(CMD_POP_FRONT, 8'h00);
      send_command(CMD_POP_BACK, 8'hFF);
      send_command(CMD_PUSH_FRONT, 8'hFF);
      send_command(CMD_PUSH_BACK, 8'h00);
      for (int i = 0; i < DEPTH - 2; i++)
         send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
      send_command(CMD_PUSH_BACK, 8'hAA);
      send_command(CMD_PUSH_FRONT, 8'h55);
      send_command(CMD_POP_FRONT, random_value());
      send_command(CMD_POP_BACK, random_value());
      for (int code = CMD_SPARE_FIRST; code <= CMD_SPARE_LAST; code++)
         send_command(3'(code), random_value());
      send_command(CMD_CLEAR, random_value());
      send_command(CMD_POP_FRONT, random_value());
      wait_drained();
   endtask

   // random walk in phases leaning toward fill, drain or neither
   task automatic test_random_walk(input int beats);
      int push_pct;
      int phase_left;
      int pick;
      phase_left = 0;
      push_pct = 50;
      for (int n = 0; n < beats; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(60, 10);
            case ($urandom_range(2, 0))
               0: push_pct = 78;
               1: push_pct = 22;
               default: push_pct = 50;
            endcase
         end
         phase_left--;
         pick = $urandom_range(99, 0);
         if (pick < 2)
            send_command(CMD_CLEAR, random_value());
         else if (pick < 4)
            send_command(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), random_value());
         else if ($urandom_range(99, 0) < push_pct)
            send_command($urandom_range(1, 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
         else
            send_command($urandom_range(1, 0) ? CMD_POP_FRONT : CMD_POP_BACK, random_value());
      end
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering, then everything drains
   task automatic test_receiver_holdoff();
      steady_sender = 1'b1;
      hold_request = 1'b1;
      for (int n = 0; n < 40; n++)
         send_command($urandom_range(1, 0) ? CMD_PUSH_BACK : CMD_POP_FRONT, random_value());
      steady_sender = 1'b0;
      wait_drained();
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      steady_sender = 1'b1;
      rsp_steady = 1'b1;
      test_random_walk(150);
      steady_sender = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_walk(RANDOM_BEATS);
      test_receiver_holdoff();
      test_back_to_back();

      wait_drained();
      if (expected_views.size() != 0) begin
         error_count++;
         $display("%0t: results missing, expected %0d more, actual 0", $time,
                  expected_views.size());
      end
      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue_unit.sv
sim/double_ended_queue_unit_test.sv
